// File: hdl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants for the gamma and brightness RGB565 converter.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PROD_W   = CHAN_W + BRIGHT_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = BRIGHT_W;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 2'd2;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_XRGB8888 = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic             en;
    logic [1:0]       ch;
    logic [CHAN_W-1:0] idx;
    logic [CHAN_W-1:0] val;
  } gbc_wr_t;

  typedef struct packed {
    logic        dim;
    logic        passthru;
    logic [15:0] raw;
  } gbc_ctl_t;

endpackage

// File: hdl/gbc_table.sv
// ----------------------------------------------------------------------------
// gbc_table
// Per-channel 256 x 8 gamma tables, one write port, registered reads.
// ----------------------------------------------------------------------------
module gbc_table
  import gbc_pkg::*;
(
  input  logic                   clk,
  input  gbc_wr_t                wr,
  input  logic                   rd_en,
  input  logic [2:0][CHAN_W-1:0] rd_idx,
  output logic [2:0][CHAN_W-1:0] rd_data
);

  logic [CHAN_W-1:0] mem_red   [256];
  logic [CHAN_W-1:0] mem_green [256];
  logic [CHAN_W-1:0] mem_blue  [256];

  always_ff @(posedge clk) begin
    if (wr.en && wr.ch == CH_RED) begin
      mem_red[wr.idx] <= wr.val;
    end
    if (wr.en && wr.ch == CH_GREEN) begin
      mem_green[wr.idx] <= wr.val;
    end
    if (wr.en && wr.ch == CH_BLUE) begin
      mem_blue[wr.idx] <= wr.val;
    end
    if (rd_en) begin
      rd_data[0] <= mem_red[rd_idx[0]];
      rd_data[1] <= mem_green[rd_idx[1]];
      rd_data[2] <= mem_blue[rd_idx[2]];
    end
  end

endmodule

// File: hdl/gbc_div.sv
// ----------------------------------------------------------------------------
// gbc_div
// Truncating divide of a scaled channel by the full-brightness constant,
// done as a multiply by a rounded-up reciprocal and a shift.
// ----------------------------------------------------------------------------
module gbc_div
  import gbc_pkg::*;
#(
  parameter int unsigned BRIGHTNESS_FULL = 100
)
(
  input  logic [PROD_W-1:0] prod,
  output logic [CHAN_W-1:0] quo
);

  localparam int unsigned L_BITS = $clog2(BRIGHTNESS_FULL);
  localparam int unsigned SHIFT  = PROD_W + L_BITS;
  localparam int unsigned MUL_W  = PROD_W + 2;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / BRIGHTNESS_FULL) + 64'd1;
  localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

  logic [PROD_W+MUL_W-1:0] wide;
  logic [PROD_W+MUL_W-1:0] shifted;

  assign wide    = (PROD_W+MUL_W)'(prod) * (PROD_W+MUL_W)'(RECIP);
  assign shifted = wide >> SHIFT;
  assign quo     = shifted[CHAN_W-1:0];

endmodule

// File: hdl/gamma_brightness_rgb565_convert.sv
// ----------------------------------------------------------------------------
// gamma_brightness_rgb565_convert
// Gamma table lookup and brightness scaling of one pixel per beat to RGB565.
//
//   channel  signals                          direction  beat carries
//   in       in_valid / in_ready              sink       table write or pixel
//   out      out_valid / out_ready            source     RGB565 pixel
//   cfg      cfg_valid / cfg_ready            sink       register index, data
//
// Three stages: table read, brightness multiply, reciprocal divide and pack.
// A pixel beat passes through the stage 1, stage 2 and output registers in
// turn; one beat is taken every cycle while the output drains. A table
// write beat takes effect at acceptance and gives no result. Each stage
// holds while the next is full and stalled. Synchronous reset empties the
// pipeline and loads register defaults; table contents are not cleared.
// ----------------------------------------------------------------------------
module gamma_brightness_rgb565_convert
  import gbc_pkg::*;
#(
  parameter int unsigned BRIGHTNESS_FULL = 100
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [1:0]            table_channel,
  input  logic [7:0]            table_index,
  input  logic [7:0]            table_value,
  input  logic [31:0]           pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           pixel_out
);

  logic [BRIGHT_W-1:0] brightness;
  logic                gamma_enable;
  logic                source_format;

  logic                   in_beat;
  logic                   dim;
  logic                   transform;
  gbc_wr_t                wr;
  logic [2:0][CHAN_W-1:0] idx0;
  gbc_ctl_t               ctl0;

  logic                   v1;
  gbc_ctl_t               ctl1;
  logic [2:0][CHAN_W-1:0] idx1;
  logic [2:0][CHAN_W-1:0] rd1;
  logic [2:0][PROD_W-1:0] prod_next;

  logic                   v2;
  gbc_ctl_t               ctl2;
  logic [2:0][PROD_W-1:0] prod2;
  logic [2:0][CHAN_W-1:0] quo2;
  logic [2:0][CHAN_W-1:0] chan2;
  logic [15:0]            pixel_next;

  logic ready2;
  logic ready3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHT_RESET;
      gamma_enable  <= 1'b0;
      source_format <= FMT_XRGB8888;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS:    brightness    <= cfg_data;
        CFG_GAMMA_ENABLE:  gamma_enable  <= cfg_data[0];
        CFG_SOURCE_FORMAT: source_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ready3   = !out_valid || out_ready;
  assign ready2   = !v2 || ready3;
  assign in_ready = !v1 || ready2;
  assign in_beat  = in_valid && in_ready;

  assign dim       = 32'(brightness) < BRIGHTNESS_FULL;
  assign transform = gamma_enable || dim;

  assign wr.en  = in_beat && func == FUNC_WRITE;
  assign wr.ch  = table_channel;
  assign wr.idx = table_index;
  assign wr.val = table_value;

  always_comb begin
    if (source_format == FMT_RGB565) begin
      idx0[0] = {3'b000, pixel_in[15:11]};
      idx0[1] = {2'b00, pixel_in[10:5]};
      idx0[2] = {3'b000, pixel_in[4:0]};
    end else begin
      idx0[0] = pixel_in[23:16];
      idx0[1] = pixel_in[15:8];
      idx0[2] = pixel_in[7:0];
    end
    ctl0.dim      = dim;
    ctl0.passthru = source_format == FMT_RGB565 && !transform;
    ctl0.raw      = pixel_in[15:0];
  end

  gbc_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (in_beat),
    .rd_idx  (idx0),
    .rd_data (rd1)
  );

  // stage 1: table entry or index, then brightness multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid && func == FUNC_CONVERT;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      ctl1 <= ctl0;
      idx1 <= idx0;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (ctl1.dim) begin
        prod_next[c] = PROD_W'(gamma_enable ? rd1[c] : idx1[c]) * PROD_W'(brightness);
      end else begin
        prod_next[c] = PROD_W'(gamma_enable ? rd1[c] : idx1[c]);
      end
    end
  end

  // stage 2: divide by full brightness and pack, or pass the raw pixel through
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      ctl2  <= ctl1;
      prod2 <= prod_next;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    gbc_div #(
      .BRIGHTNESS_FULL (BRIGHTNESS_FULL)
    ) u_div (
      .prod (prod2[c]),
      .quo  (quo2[c])
    );
    assign chan2[c] = ctl2.dim ? quo2[c] : prod2[c][CHAN_W-1:0];
  end

  assign pixel_next = ctl2.passthru ? ctl2.raw
                                    : {chan2[0][7:3], chan2[1][7:2], chan2[2][7:3]};

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      pixel_out <= pixel_next;
    end
  end

`ifndef ASSERT_OFF
  a_write_no_item: assert property (@(posedge clk) disable iff (rst)
    in_beat && func == FUNC_WRITE |=> !v1)
    else $error("table write beat entered the pipeline");

  a_convert_item: assert property (@(posedge clk) disable iff (rst)
    in_beat && func == FUNC_CONVERT |=> v1)
    else $error("pixel beat lost at table read stage");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && v2 && out_valid)
    else $error("input held off with an empty stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    v2 && out_ready |=> out_valid)
    else $error("stage 2 beat dropped on its way out");
`endif

endmodule
